### hw/rtl/dpes_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and tables of the pair energy scorer
package dpes_pkg;

   localparam int EXP_TABLE_DEPTH = 256;
   localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int EXP_P_W         = 20 + EXP_IDX_W;

   localparam int HB_LIMIT  = 180;
   localparam int HB_IDX_W  = $clog2(HB_LIMIT);

   localparam int QUEUE_DEPTH = 4;
   localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0] ROOT_LAST = 6'd15;
   localparam logic [5:0] DIV_LAST  = 6'd63;

   // flag bit positions of a kind field
   localparam int KIND_ACCEPTOR    = 0;
   localparam int KIND_DONOR       = 1;
   localparam int KIND_HYDROPHOBIC = 2;

   // coefficient magnitudes, Q16.16; all terms negative but repulsion, the torsion weight positive
   localparam logic [15:0] COEF_GAUSS1      = 16'd2332;
   localparam logic [15:0] COEF_GAUSS2      = 16'd338;
   localparam logic [15:0] COEF_REPULSION   = 16'd55066;
   localparam logic [15:0] COEF_HYDROPHOBIC = 16'd2298;
   localparam logic [15:0] COEF_HBOND       = 16'd38498;
   localparam logic [11:0] COEF_NROT        = 12'd3831;

   localparam logic [31:0] FAR_LIMIT = 32'h0040_0000;
   localparam logic [16:0] ONE_Q16   = 17'h10000;

   typedef logic [16:0] exp_tab_type [0:EXP_TABLE_DEPTH];
   typedef logic [16:0] hb_tab_type [0:HB_LIMIT-1];

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROOT, ST_SURF, ST_SQS, ST_SQT, ST_EXPA, ST_EXPB,
      ST_WEIGH, ST_SUM, ST_DIV, ST_SEND
   } back_state_type;

   typedef enum logic [2:0] {
      TERM_GAUSS1, TERM_GAUSS2, TERM_REPULSION, TERM_HYDROPHOBIC, TERM_HBOND
   } term_type;

   typedef struct packed {
      logic        far;
      logic [22:0] dist_sq;
      logic [11:0] radius_first;
      logic [11:0] radius_second;
      logic        hydrophobic;
      logic        hbond;
      logic [5:0]  torsion_count;
      logic        last_pair;
   } pair_word_type;

   // exp(-x) samples over [0,16], Q16.16
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] h;
      logic [63:0] r;
      logic [63:0] term;
      logic [63:0] e;
      h    = (64'd16 << 32) / EXP_TABLE_DEPTH;
      r    = 64'd1 << 32;
      term = 64'd1 << 32;
      e    = 64'd1 << 32;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * h) >> 32) / 64'(k);
         if ((k % 2) == 1) r = r - term;
         else r = r + term;
      end
      tab[0] = ONE_Q16;
      for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
         e = (e * r + (64'd1 << 31)) >> 32;
         tab[k] = 17'((e + 64'd32768) >> 16);
      end
      return tab;
   endfunction

   // -s / 0.7 rounded, for s in (-180/256, 0]
   function automatic hb_tab_type build_hb_tab();
      hb_tab_type tab;
      for (int m = 0; m < HB_LIMIT; m++) begin
         tab[m] = 17'((m * 2560 + 3) / 7);
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();
   localparam hb_tab_type  HB_TAB  = build_hb_tab();

endpackage

### hw/rtl/dpes_front.sv
`timescale 1ns / 1ps
// front stage: squares the coordinate differences and classifies the pair
module dpes_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic signed [15:0]           delta_x,
   input  logic signed [15:0]           delta_y,
   input  logic signed [15:0]           delta_z,
   input  logic [11:0]                  radius_first,
   input  logic [11:0]                  radius_second,
   input  logic [2:0]                   kind_first,
   input  logic [2:0]                   kind_second,
   input  logic [5:0]                   torsion_count,
   input  logic                         last_pair,
   input  logic [dpes_pkg::QCNT_W-1:0]  q_count,
   output logic                         q_push,
   output dpes_pkg::pair_word_type      q_word
);

   logic signed [31:0] prod_x, prod_y, prod_z;
   logic [30:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [11:0] r1_ff, r2_ff;
   logic        hy_ff, hb_ff, last_ff;
   logic [5:0]  tc_ff;
   logic        valid_ff;
   logic        accept;
   logic        hy_in, hb_in;
   logic [31:0] dist_sq;
   logic [dpes_pkg::QCNT_W:0] credit;

   assign credit = {1'b0, q_count} + {{dpes_pkg::QCNT_W{1'b0}}, valid_ff};
   assign full   = credit >= (dpes_pkg::QCNT_W + 1)'(dpes_pkg::QUEUE_DEPTH);
   assign accept = push && !full;

   assign prod_x = delta_x * delta_x;
   assign prod_y = delta_y * delta_y;
   assign prod_z = delta_z * delta_z;

   assign hy_in = kind_first[dpes_pkg::KIND_HYDROPHOBIC]
                  && kind_second[dpes_pkg::KIND_HYDROPHOBIC];
   assign hb_in = (kind_first[dpes_pkg::KIND_ACCEPTOR] && kind_second[dpes_pkg::KIND_DONOR])
               || (kind_second[dpes_pkg::KIND_ACCEPTOR] && kind_first[dpes_pkg::KIND_DONOR]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         sq_x_ff <= prod_x[30:0];
         sq_y_ff <= prod_y[30:0];
         sq_z_ff <= prod_z[30:0];
         r1_ff   <= radius_first;
         r2_ff   <= radius_second;
         hy_ff   <= hy_in;
         hb_ff   <= hb_in;
         tc_ff   <= torsion_count;
         last_ff <= last_pair;
      end
   end

   assign dist_sq = {1'b0, sq_x_ff} + {1'b0, sq_y_ff} + {1'b0, sq_z_ff};

   assign q_push = valid_ff;
   always_comb begin
      q_word.far           = dist_sq > dpes_pkg::FAR_LIMIT;
      q_word.dist_sq       = dist_sq[22:0];
      q_word.radius_first  = r1_ff;
      q_word.radius_second = r2_ff;
      q_word.hydrophobic   = hy_ff;
      q_word.hbond         = hb_ff;
      q_word.torsion_count = tc_ff;
      q_word.last_pair     = last_ff;
   end

endmodule

### hw/rtl/dpes_queue.sv
`timescale 1ns / 1ps
// short queue of classified pairs between front and back
module dpes_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  dpes_pkg::pair_word_type      push_word,
   input  logic                         pop,
   output logic                         empty,
   output dpes_pkg::pair_word_type      head,
   output logic [dpes_pkg::QCNT_W-1:0]  count
);

   dpes_pkg::pair_word_type mem_ff [0:dpes_pkg::QUEUE_DEPTH-1];
   logic [dpes_pkg::QADDR_W-1:0] wr_ff, rd_ff;
   logic [dpes_pkg::QCNT_W-1:0]  count_ff;
   logic do_pop;

   assign empty  = count_ff == '0;
   assign count  = count_ff;
   assign head   = mem_ff[rd_ff];
   assign do_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         if (push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (!push && do_pop) count_ff <= count_ff - 1'b1;
      end
      if (push) mem_ff[wr_ff] <= push_word;
   end

endmodule

### hw/rtl/dpes_back.sv
`timescale 1ns / 1ps
// back end: root, energy terms, saturating sum and pose normalization
module dpes_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  dpes_pkg::pair_word_type  q_head,
   output logic                     q_pop,
   output logic                     res_valid,
   output logic signed [31:0]       res_score,
   input  logic                     res_ready
);

   dpes_pkg::back_state_type state_ff, state_in;
   dpes_pkg::term_type       term_ff;
   dpes_pkg::pair_word_type  word_ff;

   logic [5:0]  cnt_ff;
   logic [31:0] v_ff, root_ff, bit_ff;
   logic signed [14:0] s_ff;
   logic [25:0] sq_s_ff;
   logic [26:0] sq_t_ff;
   logic [16:0] exp_a_ff, exp_b_ff, exp_ff;
   logic [19:0] frac_ff;
   logic        exp_zero_ff;
   logic signed [31:0] e_ff;
   logic signed [47:0] esum_ff;
   logic [63:0] num_ff;
   logic [18:0] rem_ff, den_ff;
   logic        neg_ff;

   // root step
   logic [31:0] trial;
   logic        take;
   // surface distance and squares
   logic signed [14:0] s_in;
   logic signed [29:0] s_prod;
   logic signed [15:0] t_val;
   logic signed [31:0] t_prod;
   // table interpolation
   logic [27:0] exp_x;
   logic [dpes_pkg::EXP_P_W-1:0] exp_p;
   logic [dpes_pkg::EXP_IDX_W-1:0] exp_idx, exp_idx_nx;
   logic [16:0] exp_diff;
   logic [36:0] exp_dprod;
   logic [16:0] exp_in;
   // weighting
   logic [25:0] term_val;
   logic [15:0] coef_mag;
   logic        coef_neg;
   logic [41:0] wprod;
   logic [25:0] wround;
   logic [7:0]  hb_mag;
   // sum and division
   logic signed [48:0] sum49;
   logic signed [47:0] sum_sat;
   logic [47:0] mag;
   logic [18:0] den_in;
   logic [19:0] rem_sh;
   logic        ge;

   assign trial = root_ff + bit_ff;
   assign take  = v_ff >= trial;

   assign s_in = $signed({3'b000, root_ff[11:0]}) - $signed({3'b000, word_ff.radius_first})
               - $signed({3'b000, word_ff.radius_second});
   assign s_prod = s_ff * s_ff;
   assign t_val  = {s_ff[14], s_ff} - 16'sd768;
   assign t_prod = t_val * t_val;

   assign exp_x = (term_ff == dpes_pkg::TERM_GAUSS1) ? {sq_s_ff, 2'b00}
                                                     : {3'b000, sq_t_ff[26:2]};
   assign exp_p      = dpes_pkg::EXP_P_W'(exp_x[19:0])
                     * dpes_pkg::EXP_P_W'(dpes_pkg::EXP_TABLE_DEPTH);
   assign exp_idx    = exp_p[dpes_pkg::EXP_P_W-1:20];
   assign exp_idx_nx = exp_idx + 1'b1;

   assign exp_diff  = exp_a_ff - exp_b_ff;
   assign exp_dprod = exp_diff * frac_ff;
   always_comb begin
      if (exp_zero_ff) exp_in = '0;
      else if (exp_a_ff < exp_b_ff) exp_in = exp_a_ff;
      else exp_in = exp_a_ff - exp_dprod[36:20];
   end

   assign hb_mag = 8'(-s_ff);

   // term value and coefficient of the current term
   always_comb begin
      term_val = '0;
      coef_mag = dpes_pkg::COEF_GAUSS1;
      coef_neg = 1'b1;
      case (term_ff)
         dpes_pkg::TERM_GAUSS1: begin
            if (s_ff != 0) term_val = {9'd0, exp_ff};
         end
         dpes_pkg::TERM_GAUSS2: begin
            coef_mag = dpes_pkg::COEF_GAUSS2;
            if (s_ff != 0) term_val = {9'd0, exp_ff};
         end
         dpes_pkg::TERM_REPULSION: begin
            coef_mag = dpes_pkg::COEF_REPULSION;
            coef_neg = 1'b0;
            if (s_ff < 0) term_val = sq_s_ff;
         end
         dpes_pkg::TERM_HYDROPHOBIC: begin
            coef_mag = dpes_pkg::COEF_HYDROPHOBIC;
            if (word_ff.hydrophobic) begin
               if (s_ff <= 15'sd128) term_val = {9'd0, dpes_pkg::ONE_Q16};
               else if (s_ff < 15'sd384) term_val = 26'(15'sd384 - s_ff) << 8;
            end
         end
         dpes_pkg::TERM_HBOND: begin
            coef_mag = dpes_pkg::COEF_HBOND;
            if (word_ff.hbond) begin
               if (s_ff <= -15'sd180) term_val = {9'd0, dpes_pkg::ONE_Q16};
               else if (s_ff < 0) term_val = {9'd0, dpes_pkg::HB_TAB[hb_mag]};
            end
         end
         default: term_val = '0;
      endcase
   end

   assign wprod  = 42'(term_val) * 42'(coef_mag) + 42'd32768;
   assign wround = wprod[41:16];

   assign sum49 = {esum_ff[47], esum_ff} + 49'(e_ff);
   always_comb begin
      if (sum49 > 49'sh0_7FFF_FFFF_FFFF) sum_sat = 48'sh7FFF_FFFF_FFFF;
      else if (sum49 < -49'sh0_8000_0000_0000) sum_sat = 48'sh8000_0000_0000;
      else sum_sat = sum49[47:0];
   end
   assign mag    = sum_sat[47] ? 48'(-sum_sat) : 48'(sum_sat);
   assign den_in = 19'd65536 + dpes_pkg::COEF_NROT * word_ff.torsion_count;

   assign rem_sh = {rem_ff, num_ff[63]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpes_pkg::ST_IDLE: begin
            if (!q_empty) state_in = q_head.far ? dpes_pkg::ST_SUM : dpes_pkg::ST_ROOT;
         end
         dpes_pkg::ST_ROOT: begin
            if (cnt_ff == dpes_pkg::ROOT_LAST) state_in = dpes_pkg::ST_SURF;
         end
         dpes_pkg::ST_SURF: state_in = dpes_pkg::ST_SQS;
         dpes_pkg::ST_SQS:  state_in = dpes_pkg::ST_SQT;
         dpes_pkg::ST_SQT:  state_in = dpes_pkg::ST_EXPA;
         dpes_pkg::ST_EXPA: state_in = dpes_pkg::ST_EXPB;
         dpes_pkg::ST_EXPB: state_in = dpes_pkg::ST_WEIGH;
         dpes_pkg::ST_WEIGH: begin
            if (term_ff == dpes_pkg::TERM_GAUSS1) state_in = dpes_pkg::ST_EXPA;
            else if (term_ff == dpes_pkg::TERM_HBOND) state_in = dpes_pkg::ST_SUM;
         end
         dpes_pkg::ST_SUM: begin
            state_in = word_ff.last_pair ? dpes_pkg::ST_DIV : dpes_pkg::ST_IDLE;
         end
         dpes_pkg::ST_DIV: begin
            if (cnt_ff == dpes_pkg::DIV_LAST) state_in = dpes_pkg::ST_SEND;
         end
         dpes_pkg::ST_SEND: begin
            if (res_ready) state_in = dpes_pkg::ST_IDLE;
         end
         default: state_in = dpes_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = 1'b0;
      res_valid = 1'b0;
      unique case (state_ff)
         dpes_pkg::ST_IDLE: q_pop     = !q_empty;
         dpes_pkg::ST_SEND: res_valid = 1'b1;
         default: begin
            q_pop     = 1'b0;
            res_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (neg_ff) begin
         if (num_ff > 64'h8000_0000) res_score = 32'sh8000_0000;
         else res_score = -$signed(num_ff[31:0]);
      end else begin
         if (num_ff > 64'h7FFF_FFFF) res_score = 32'sh7FFF_FFFF;
         else res_score = $signed(num_ff[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpes_pkg::ST_IDLE;
         esum_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == dpes_pkg::ST_SUM) esum_ff <= word_ff.last_pair ? '0 : sum_sat;
      end
      unique case (state_ff)
         dpes_pkg::ST_IDLE: begin
            word_ff <= q_head;
            v_ff    <= {9'd0, q_head.dist_sq};
            root_ff <= '0;
            bit_ff  <= 32'h4000_0000;
            cnt_ff  <= '0;
            e_ff    <= '0;
         end
         dpes_pkg::ST_ROOT: begin
            if (take) begin
               v_ff    <= v_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 1'b1;
         end
         dpes_pkg::ST_SURF: s_ff <= s_in;
         dpes_pkg::ST_SQS:  sq_s_ff <= s_prod[25:0];
         dpes_pkg::ST_SQT: begin
            sq_t_ff <= t_prod[26:0];
            term_ff <= dpes_pkg::TERM_GAUSS1;
         end
         dpes_pkg::ST_EXPA: begin
            exp_zero_ff <= |exp_x[27:20];
            exp_a_ff    <= dpes_pkg::EXP_TAB[exp_idx];
            exp_b_ff    <= dpes_pkg::EXP_TAB[exp_idx_nx];
            frac_ff     <= exp_p[19:0];
         end
         dpes_pkg::ST_EXPB: exp_ff <= exp_in;
         dpes_pkg::ST_WEIGH: begin
            e_ff <= coef_neg ? e_ff - $signed({6'd0, wround}) : e_ff + $signed({6'd0, wround});
            case (term_ff)
               dpes_pkg::TERM_GAUSS1:      term_ff <= dpes_pkg::TERM_GAUSS2;
               dpes_pkg::TERM_GAUSS2:      term_ff <= dpes_pkg::TERM_REPULSION;
               dpes_pkg::TERM_REPULSION:   term_ff <= dpes_pkg::TERM_HYDROPHOBIC;
               dpes_pkg::TERM_HYDROPHOBIC: term_ff <= dpes_pkg::TERM_HBOND;
               default:                    term_ff <= dpes_pkg::TERM_HBOND;
            endcase
         end
         dpes_pkg::ST_SUM: begin
            num_ff <= {mag, 16'd0} + 64'(den_in >> 1);
            den_ff <= den_in;
            neg_ff <= sum_sat[47];
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         dpes_pkg::ST_DIV: begin
            rem_ff <= ge ? 19'(rem_sh - {1'b0, den_ff}) : rem_sh[18:0];
            num_ff <= {num_ff[62:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: cnt_ff <= cnt_ff;
      endcase
   end

endmodule

### hw/rtl/docking_pair_energy_scorer_top.sv
`timescale 1ns / 1ps
// top level of the docking pair energy scorer: front, pair queue, back, result register
// a pair beyond 8 A goes straight to the sum in the back end; a near pair goes through the
//    16-step bit-serial root, two table interpolations and five weighted terms
// a last pair then runs the 64-step restoring divide and passes on to the result register
// the back end sequencer takes one pair at a time and pops the next only once it is done;
//    the front keeps taking pairs while the four-entry queue has room
// reset (synchronous, active high) clears the energy sum, queue and result register
module docking_pair_energy_scorer_top (
   input  logic               clock,
   input  logic               reset,
   // input word
   input  logic               push,
   output logic               full,
   input  logic signed [15:0] req_delta_x,
   input  logic signed [15:0] req_delta_y,
   input  logic signed [15:0] req_delta_z,
   input  logic [11:0]        req_radius_first,
   input  logic [11:0]        req_radius_second,
   input  logic [2:0]         req_kind_first,
   input  logic [2:0]         req_kind_second,
   input  logic [5:0]         req_torsion_count,
   input  logic               req_last_pair,
   // result word
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_pose_score
);

   // front to queue
   logic                          q_push;
   dpes_pkg::pair_word_type       q_word;
   // queue to back
   logic                          q_empty;
   logic                          q_pop;
   dpes_pkg::pair_word_type       q_head;
   logic [dpes_pkg::QCNT_W-1:0]   q_count;
   // back to result register
   logic                          res_valid;
   logic                          res_ready;
   logic signed [31:0]            res_score;
   // result register
   logic                          rsp_valid_ff;
   logic signed [31:0]            rsp_score_ff;

   // squares and pair classification
   dpes_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .delta_x       (req_delta_x),
      .delta_y       (req_delta_y),
      .delta_z       (req_delta_z),
      .radius_first  (req_radius_first),
      .radius_second (req_radius_second),
      .kind_first    (req_kind_first),
      .kind_second   (req_kind_second),
      .torsion_count (req_torsion_count),
      .last_pair     (req_last_pair),
      .q_count       (q_count),
      .q_push        (q_push),
      .q_word        (q_word)
   );

   // decouples the front from the multi-cycle back end
   dpes_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_word),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head),
      .count     (q_count)
   );

   // energy evaluation, accumulation and normalization
   dpes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .res_valid (res_valid),
      .res_score (res_score),
      .res_ready (res_ready)
   );

   // result register frees as it is popped
   assign res_ready = !rsp_valid_ff || pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_valid && res_ready) rsp_score_ff <= res_score;
   end

   assign empty          = !rsp_valid_ff;
   assign rsp_pose_score = rsp_score_ff;

endmodule

### tb/docking_pair_energy_scorer_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the docking pair energy scorer top level
module docking_pair_energy_scorer_top_test;

   localparam int TAB_DEPTH  = dpes_pkg::EXP_TABLE_DEPTH;
   localparam int RAND_ITEMS = 750;
   localparam int IDLE_PCT   = 13;
   localparam int STALL_MAX  = 4000;  // cycles with no word accepted on either side
   localparam int DRAIN_WAIT = 100;

   localparam logic [2:0] KIND_NONE = 3'b000;
   localparam logic [2:0] KIND_ACC  = 3'b001;
   localparam logic [2:0] KIND_DON  = 3'b010;
   localparam logic [2:0] KIND_HYD  = 3'b100;
   localparam logic [2:0] KIND_ALL  = 3'b111;

   // scoreboard: fixed point model of the scorer plus the pending pose scores
   class pose_scoreboard;
      longint unsigned exp_samples [0:TAB_DEPTH];
      longint          energy_acc;
      logic signed [31:0] score_queue [$];
      int              errors;

      function new();
         longint unsigned h, r, term, e;
         h = (64'd16 << 32) / TAB_DEPTH;
         r = 64'd1 << 32;
         term = 64'd1 << 32;
         e = 64'd1 << 32;
         for (int k = 1; k <= 24; k++) begin
            term = ((term * h) >> 32) / longint'(k);
            if (k % 2) r -= term;
            else r += term;
         end
         exp_samples[0] = 65536;
         for (int k = 1; k <= TAB_DEPTH; k++) begin
            e = (e * r + (64'd1 << 31)) >> 32;
            exp_samples[k] = (e + 32768) >> 16;
         end
         energy_acc = 0;
         errors = 0;
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      function longint unsigned exp_neg(longint unsigned x);
         longint unsigned p, idx, frac, a, b;
         if (x >= (64'd16 << 16)) return 0;
         p = x * TAB_DEPTH;
         idx = p >> 20;
         if (idx >= TAB_DEPTH) return 0;
         frac = p & 64'hFFFFF;
         a = exp_samples[idx];
         b = exp_samples[idx + 1];
         if (a < b) return a;
         return a - (((a - b) * frac) >> 20);
      endfunction

      function longint unsigned int_root(longint unsigned v);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 30;
         for (int i = 0; i < 16; i++) begin
            if (v >= root + bitv) begin
               v -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      function longint weigh(longint coef, longint unsigned term);
         longint unsigned mag, prod;
         mag = (coef < 0) ? -coef : coef;
         prod = (mag * term + 32768) >> 16;
         return (coef < 0) ? -longint'(prod) : longint'(prod);
      endfunction

      function longint pair_energy(logic signed [15:0] dx, logic signed [15:0] dy,
                                   logic signed [15:0] dz, logic [11:0] r1, logic [11:0] r2,
                                   logic [2:0] k1, logic [2:0] k2);
         longint q, s, t, e;
         bit hb, hy;
         q = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz;
         hb = (k1[0] && k2[1]) || (k2[0] && k1[1]);
         hy = k1[2] && k2[2];
         e = 0;
         if (q > (64'd64 << 16)) return 0;
         s = longint'(int_root(q)) - longint'(r1) - longint'(r2);
         // zero surface distance drops both gaussians
         if (s != 0) begin
            e += weigh(-2332, exp_neg(4 * s * s));
            t = s - 768;
            e += weigh(-338, exp_neg((t * t) >> 2));
         end
         if (s < 0) e += weigh(55066, s * s);
         if (hy) begin
            if (s <= 128) e += weigh(-2298, 65536);
            else if (s < 384) e += weigh(-2298, (384 - s) << 8);
         end
         if (hb) begin
            if (s <= -180) e += weigh(-38498, 65536);
            else if (s < 0) e += weigh(-38498, ((-s) * 2560 + 3) / 7);
         end
         return e;
      endfunction

      function void note_pair(logic signed [15:0] dx, logic signed [15:0] dy,
                              logic signed [15:0] dz, logic [11:0] r1, logic [11:0] r2,
                              logic [2:0] k1, logic [2:0] k2, logic [5:0] tc, logic last);
         longint sum;
         longint unsigned mag, den, quo;
         longint score;
         sum = energy_acc + pair_energy(dx, dy, dz, r1, r2, k1, k2);
         if (sum > 64'sd140737488355327) sum = 64'sd140737488355327;
         if (sum < -64'sd140737488355328) sum = -64'sd140737488355328;
         energy_acc = sum;
         if (last) begin
            den = 65536 + 3831 * longint'(tc);
            mag = (sum < 0) ? -sum : sum;
            quo = ((mag << 16) + den / 2) / den;
            if (sum < 0) score = (quo > 64'd2147483648) ? -64'sd2147483648 : -longint'(quo);
            else score = (quo > 64'd2147483647) ? 64'sd2147483647 : longint'(quo);
            score_queue.push_back(32'(score));
            energy_acc = 0;
         end
      endfunction

      task check_score(logic signed [31:0] got);
         logic signed [31:0] want;
         if (score_queue.size() == 0) begin
            report($sformatf("unexpected pose_score %0d", got));
         end else begin
            want = score_queue.pop_front();
            if (got !== want) report($sformatf("pose_score %0d, want %0d", got, want));
         end
      endtask

      function int pending();
         return score_queue.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic signed [15:0] req_delta_x = '0;
   logic signed [15:0] req_delta_y = '0;
   logic signed [15:0] req_delta_z = '0;
   logic [11:0]        req_radius_first = '0;
   logic [11:0]        req_radius_second = '0;
   logic [2:0]         req_kind_first = '0;
   logic [2:0]         req_kind_second = '0;
   logic [5:0]         req_torsion_count = '0;
   logic               req_last_pair = 1'b0;
   logic               empty;
   logic               pop = 1'b0;
   logic signed [31:0] rsp_pose_score;

   pose_scoreboard sb = new();
   bit  calm = 1'b0;   // set over a stretch of the run: no idling on either side
   int  stall_cycles = 0;

   docking_pair_energy_scorer_top uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_delta_x(req_delta_x), .req_delta_y(req_delta_y), .req_delta_z(req_delta_z),
      .req_radius_first(req_radius_first), .req_radius_second(req_radius_second),
      .req_kind_first(req_kind_first), .req_kind_second(req_kind_second),
      .req_torsion_count(req_torsion_count), .req_last_pair(req_last_pair),
      .empty(empty), .pop(pop), .rsp_pose_score(rsp_pose_score)
   );

   always #5 clock = ~clock;

   // drive one pair word and hold it until the front takes it
   task send_pair(logic signed [15:0] dx, logic signed [15:0] dy, logic signed [15:0] dz,
                  logic [11:0] r1, logic [11:0] r2, logic [2:0] k1, logic [2:0] k2,
                  logic [5:0] tc, logic last);
      // random gap before the word, skipped in the calm stretch
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      push <= 1'b1;
      req_delta_x <= dx;
      req_delta_y <= dy;
      req_delta_z <= dz;
      req_radius_first <= r1;
      req_radius_second <= r2;
      req_kind_first <= k1;
      req_kind_second <= k2;
      req_torsion_count <= tc;
      req_last_pair <= last;
      // values seen here are those the edge sampled
      do @(posedge clock); while (full);
      sb.note_pair(dx, dy, dz, r1, r2, k1, k2, tc, last);
   endtask

   // random pair: deltas within the 8 A cutoff for seven pairs in ten, else fully random
   task send_random_pair();
      logic signed [15:0] dx, dy, dz;
      logic [11:0] r1, r2;
      if ($urandom_range(0, 99) < 70) begin
         dx = 16'($urandom_range(0, 2364) - 1182);
         dy = 16'($urandom_range(0, 2364) - 1182);
         dz = 16'($urandom_range(0, 2364) - 1182);
      end else begin
         dx = 16'($urandom);
         dy = 16'($urandom);
         dz = 16'($urandom);
      end
      if ($urandom_range(0, 99) < 80) begin
         r1 = 12'($urandom_range(150, 700));
         r2 = 12'($urandom_range(150, 700));
      end else begin
         r1 = 12'($urandom);
         r2 = 12'($urandom);
      end
      send_pair(dx, dy, dz, r1, r2, 3'($urandom), 3'($urandom), 6'($urandom),
                $urandom_range(0, 7) == 0);
   endtask

   // result side: random pop, compare on every accepted word
   initial begin
      forever begin
         @(posedge clock);
         if (pop && !empty) sb.check_score(rsp_pose_score);
         pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
         $display("docking_pair_energy_scorer_top regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: cutoff extremes, zero surface distance, term boundaries
      send_pair(-16'sd32768, -16'sd32768, -16'sd32768, 12'd0, 12'd0, KIND_ALL, KIND_ALL,
                6'd63, 1'b1);
      send_pair(16'sd32767, 16'sd32767, 16'sd32767, 12'd4095, 12'd4095, KIND_ALL, KIND_ALL,
                6'd0, 1'b1);
      send_pair(16'sd0, 16'sd0, 16'sd0, 12'd0, 12'd0, KIND_ALL, KIND_ALL, 6'd0, 1'b1);
      send_pair(16'sd128, 16'sd0, 16'sd0, 12'd0, 12'd0, KIND_HYD, KIND_HYD, 6'd0, 1'b1);
      send_pair(16'sd0, 16'sd256, 16'sd0, 12'd0, 12'd0, KIND_HYD, KIND_HYD, 6'd1, 1'b1);
      send_pair(16'sd0, 16'sd0, 16'sd384, 12'd0, 12'd0, KIND_HYD, KIND_ALL, 6'd2, 1'b1);
      send_pair(16'sd0, 16'sd0, 16'sd0, 12'd180, 12'd0, KIND_ACC, KIND_DON, 6'd3, 1'b1);
      send_pair(16'sd0, 16'sd0, 16'sd0, 12'd0, 12'd179, KIND_DON, KIND_ACC, 6'd4, 1'b1);
      send_pair(16'sd0, 16'sd1, 16'sd0, 12'd1, 12'd1, KIND_ACC | KIND_DON, KIND_ACC,
                6'd5, 1'b1);
      send_pair(16'sd0, 16'sd0, 16'sd0, 12'd4095, 12'd4095, KIND_NONE, KIND_NONE,
                6'd63, 1'b1);
      send_pair(16'sd2048, 16'sd0, 16'sd0, 12'd0, 12'd0, KIND_NONE, KIND_NONE, 6'd0, 1'b1);
      send_pair(-16'sd2049, 16'sd0, 16'sd0, 12'd0, 12'd0, KIND_ALL, KIND_ALL, 6'd0, 1'b1);
      send_pair(16'sd768, 16'sd0, 16'sd0, 12'd0, 12'd0, KIND_NONE, KIND_NONE, 6'd7, 1'b1);
      send_pair(-16'sd1000, -16'sd500, 16'sd300, 12'd300, 12'd400, KIND_HYD | KIND_ACC,
                KIND_HYD | KIND_DON, 6'd10, 1'b1);
      // several pairs summed into one pose
      for (int i = 0; i < 6; i++) begin
         send_pair(16'(i * 200), -16'sd100, 16'sd50, 12'(400 + i * 500), 12'd4095,
                   KIND_ALL, KIND_ACC, 6'd0, i == 5);
      end

      // random part, with a calm stretch in the middle
      for (int n = 0; n < RAND_ITEMS; n++) begin
         calm = (n >= 300) && (n < 420);
         send_random_pair();
      end
      calm = 1'b0;
      // close the last pose so every pair ends up in a score
      send_pair(16'sd0, 16'sd0, 16'sd0, 12'd0, 12'd0, KIND_NONE, KIND_NONE, 6'd0, 1'b1);
      push <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.pending() != 0) sb.report("pose scores never arrived");
      if (sb.errors == 0) begin
         $display("docking_pair_energy_scorer_top regression: pass");
      end else begin
         $display("docking_pair_energy_scorer_top regression: fail");
      end
      $finish;
   end

endmodule
